// ----- rtl/component_clique_check_top_assert.svh -----
// Assertion macros for the component clique checker.
`ifndef COMPONENT_CLIQUE_CHECK_TOP_ASSERT_SVH
`define COMPONENT_CLIQUE_CHECK_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ccc_pkg.sv -----
// Shared types and constants for the component clique checker.
package ccc_pkg;

  localparam int NODE_W = 11;
  localparam int EDGE_W = 20;
  localparam int PAIR_W = 19;

  localparam logic [EDGE_W-1:0] EDGE_MAX = 20'hFFFFF;
  localparam logic [PAIR_W-1:0] PAIR_MAX = 19'h7FFFF;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_RD,
    ST_U_CHK,
    ST_V_RD,
    ST_V_CHK,
    ST_LINK_A,
    ST_LINK_B,
    ST_FIN_RD,
    ST_FIN_CHK,
    ST_TALLY,
    ST_REPORT
  } state_t;

endpackage

// ----- rtl/ccc_ram.sv -----
// Single-port-write, single-port-read memory with registered read data.
module ccc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 21,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry and register one read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/component_clique_check_top.sv -----
// Component clique checker: union-find over edges, component pair sum at finish.
// Add item: busy while it walks u to its root and then v to its root, plus ST_LINK_A and
// ST_LINK_B when the roots are joined; a bad edge leaves the block idle. Union by size bounds each path by log2(nodes).
// Finish item: for each node a walk to its root and a tally step, then a report state,
// then the result strobe as a clearing pass over both memories begins.
// Reset runs the same clearing pass, with busy high; node_count resets to 1024 and is
// kept across the clear that follows a result.
`include "component_clique_check_top_assert.svh"

module component_clique_check_top import ccc_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [NODE_W-1:0] node_u,
  input  logic [NODE_W-1:0] node_v,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_wdata,
  output logic              done,
  output logic              is_perfect,
  output logic [EDGE_W-1:0] edge_total,
  output logic [PAIR_W-1:0] pair_sum,
  output logic              bad_edge
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int SZW = AW + 1;
  localparam int NWW = SZW + AW;
  localparam int SW  = 2 * AW;
  localparam int CW  = (SW > EDGE_W) ? SW : EDGE_W;
  localparam int IW  = (SZW > NODE_W) ? SZW : NODE_W;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_NODES - 1);

  state_t state, state_next;

  logic [NODE_W-1:0] node_count;
  logic [EDGE_W-1:0] edge_cnt;
  logic              err_flag;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     v_hold;
  logic [AW-1:0]     root_u;
  logic [SZW-1:0]    size_u;
  logic [AW-1:0]     big_root;
  logic [AW-1:0]     small_root;
  logic [SZW-1:0]    big_size;
  logic [SZW-1:0]    small_size;
  logic [AW-1:0]     node_idx;
  logic [AW-1:0]     last_idx;
  logic [SW-1:0]     sum;

  // Memory ports
  logic           nd_we, tl_we;
  logic [AW-1:0]  nd_waddr, nd_raddr, tl_waddr, tl_raddr;
  logic [NWW-1:0] nd_wdata, nd_q;
  logic [SZW-1:0] tl_wdata, tl_q;

  // Decode the input item
  logic [IW-1:0] eff, u_w, v_w;
  logic          edge_bad;
  logic [AW-1:0] u_idx, v_idx;

  assign eff = (IW'(node_count) > IW'(MAX_NODES)) ? IW'(MAX_NODES) : IW'(node_count);
  assign u_w = IW'(node_u);
  assign v_w = IW'(node_v);
  assign edge_bad = (u_w == '0) || (v_w == '0) || (u_w > eff) || (v_w > eff);
  assign u_idx = AW'(u_w - IW'(1));
  assign v_idx = AW'(v_w - IW'(1));

  // Split the node entry read back
  logic [AW-1:0]  rd_parent;
  logic [SZW-1:0] rd_size;
  logic           is_root;

  assign rd_parent = nd_q[AW-1:0];
  assign rd_size   = nd_q[NWW-1:AW];
  assign is_root   = (rd_parent == cur);

  assign busy = (state != ST_IDLE);

  // Node memory: parent link and component size
  ccc_ram #(.DEPTH(MAX_NODES), .WIDTH(NWW)) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_q)
  );

  // Tally memory: nodes counted so far per root during finish
  ccc_ram #(.DEPTH(MAX_NODES), .WIDTH(SZW)) u_tally_ram (
    .clk   (clk),
    .we    (tl_we),
    .waddr (tl_waddr),
    .wdata (tl_wdata),
    .raddr (tl_raddr),
    .rdata (tl_q)
  );

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the walks and drive the memory ports
  always_comb begin
    state_next = state;
    nd_we      = 1'b0;
    nd_waddr   = cur;
    nd_wdata   = '0;
    nd_raddr   = cur;
    tl_we      = 1'b0;
    tl_waddr   = cur;
    tl_wdata   = '0;
    tl_raddr   = cur;
    case (state)
      ST_CLEAR: begin
        nd_we    = 1'b1;
        nd_waddr = node_idx;
        nd_wdata = {SZW'(1), node_idx};
        tl_we    = 1'b1;
        tl_waddr = node_idx;
        if (node_idx == LAST_ENTRY) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (op == OP_FINISH) begin
            state_next = (eff == '0) ? ST_REPORT : ST_FIN_RD;
          end else if (!edge_bad) begin
            state_next = ST_U_RD;
          end
        end
      end
      ST_U_RD: begin
        state_next = ST_U_CHK;
      end
      ST_U_CHK: begin
        if (is_root) begin
          state_next = ST_V_RD;
        end else begin
          nd_raddr = rd_parent;
        end
      end
      ST_V_RD: begin
        state_next = ST_V_CHK;
      end
      ST_V_CHK: begin
        if (is_root) begin
          state_next = (cur == root_u) ? ST_IDLE : ST_LINK_A;
        end else begin
          nd_raddr = rd_parent;
        end
      end
      ST_LINK_A: begin
        nd_we      = 1'b1;
        nd_waddr   = small_root;
        nd_wdata   = {small_size, big_root};
        state_next = ST_LINK_B;
      end
      ST_LINK_B: begin
        nd_we      = 1'b1;
        nd_waddr   = big_root;
        nd_wdata   = {SZW'(big_size + small_size), big_root};
        state_next = ST_IDLE;
      end
      ST_FIN_RD: begin
        state_next = ST_FIN_CHK;
      end
      ST_FIN_CHK: begin
        if (is_root) begin
          state_next = ST_TALLY;
        end else begin
          nd_raddr = rd_parent;
        end
      end
      ST_TALLY: begin
        tl_we      = 1'b1;
        tl_wdata   = SZW'(tl_q + 1'b1);
        state_next = (node_idx == last_idx) ? ST_REPORT : ST_FIN_RD;
      end
      ST_REPORT: begin
        state_next = ST_CLEAR;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers: counters, flags, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      edge_cnt   <= '0;
      err_flag   <= 1'b0;
      node_idx   <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      case (state)
        ST_CLEAR: begin
          node_idx <= (node_idx == LAST_ENTRY) ? '0 : AW'(node_idx + 1'b1);
        end
        ST_IDLE: begin
          if (start) begin
            if (op == OP_FINISH) begin
              node_idx <= '0;
            end else if (edge_bad) begin
              err_flag <= 1'b1;
            end else if (edge_cnt != EDGE_MAX) begin
              edge_cnt <= edge_cnt + 1'b1;
            end
          end
        end
        ST_TALLY: begin
          node_idx <= AW'(node_idx + 1'b1);
        end
        ST_REPORT: begin
          done     <= 1'b1;
          edge_cnt <= '0;
          err_flag <= 1'b0;
          node_idx <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: walk pointer, roots, sizes, pair sum, result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (op == OP_FINISH) begin
            cur      <= '0;
            last_idx <= AW'(eff - IW'(1));
            sum      <= '0;
          end else begin
            cur    <= u_idx;
            v_hold <= v_idx;
          end
        end
      end
      ST_U_CHK: begin
        if (is_root) begin
          root_u <= cur;
          size_u <= rd_size;
          cur    <= v_hold;
        end else begin
          cur <= rd_parent;
        end
      end
      ST_V_CHK: begin
        if (is_root) begin
          // Attach the smaller tree under the larger, u wins a tie
          if (size_u < rd_size) begin
            big_root   <= cur;
            big_size   <= rd_size;
            small_root <= root_u;
            small_size <= size_u;
          end else begin
            big_root   <= root_u;
            big_size   <= size_u;
            small_root <= cur;
            small_size <= rd_size;
          end
        end else begin
          cur <= rd_parent;
        end
      end
      ST_FIN_CHK: begin
        if (!is_root) begin
          cur <= rd_parent;
        end
      end
      ST_TALLY: begin
        // Each node adds the count of earlier nodes in its component
        sum <= SW'(sum + SW'(tl_q));
        cur <= AW'(node_idx + 1'b1);
      end
      ST_REPORT: begin
        is_perfect <= (CW'(sum) == CW'(edge_cnt));
        edge_total <= edge_cnt;
        pair_sum   <= (CW'(sum) > CW'(PAIR_MAX)) ? PAIR_MAX : PAIR_W'(sum);
        bad_edge   <= err_flag;
      end
      default: begin
      end
    endcase
  end

  `CCC_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")
  `CCC_ASSERT_NOW(a_done_cleared, done, (edge_cnt == '0) && !err_flag, "state not cleared at result")
  `CCC_ASSERT_NEXT(a_add_walks, start && !busy && (op == OP_ADD) && !edge_bad, busy, "good edge not walked")
  `CCC_ASSERT_NEXT(a_bad_sticky, start && !busy && (op == OP_ADD) && edge_bad, err_flag, "bad edge not flagged")
  `CCC_ASSERT_NOW(a_link_roots, state == ST_LINK_A, big_root != small_root, "joining a root to itself")

endmodule

// ----- tb/sv/clique_report_checker.sv -----
// Report checker for the component clique checker: tracks the edge forest and compares reports.
`timescale 1ns / 1ps

module clique_report_checker import ccc_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              op,
  input  logic [NODE_W-1:0] node_u,
  input  logic [NODE_W-1:0] node_v,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_wdata,
  input  logic              done,
  input  logic              is_perfect,
  input  logic [EDGE_W-1:0] edge_total,
  input  logic [PAIR_W-1:0] pair_sum,
  input  logic              bad_edge,
  output int                fail_count,
  output int                reports_pending
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int SIZE_W = IDX_W + 1;

  typedef struct packed {
    logic              is_perfect;
    logic [EDGE_W-1:0] edge_total;
    logic [PAIR_W-1:0] pair_sum;
    logic              bad_edge;
  } clique_report_t;

  clique_report_t    report_q[$];
  logic [NODE_W-1:0] node_limit;
  logic [IDX_W-1:0]  parent_of [MAX_NODES];
  logic [IDX_W:0]    group_size [MAX_NODES];
  int                member_tally [MAX_NODES];
  logic [EDGE_W-1:0] edges_seen;
  logic              bad_seen;

  // Put every node back in a group of its own
  task automatic clear_forest();
    for (int i = 0; i < MAX_NODES; i++) begin
      parent_of[i] = IDX_W'(i);
      group_size[i] = SIZE_W'(1);
    end
    edges_seen = '0;
    bad_seen = 1'b0;
  endtask

  function automatic int live_nodes();
    return (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
  endfunction

  function automatic int root_of(int x);
    int steps;
    steps = 0;
    while (parent_of[x] != x && steps < MAX_NODES) begin
      x = int'(parent_of[x]);
      steps++;
    end
    return x;
  endfunction

  // Count a valid edge and merge its groups, the smaller under the larger
  task automatic join_edge(logic [NODE_W-1:0] u, logic [NODE_W-1:0] v);
    int n;
    int ru;
    int rv;
    int swap;
    n = live_nodes();
    if (u == 0 || v == 0 || u > n || v > n) begin
      bad_seen = 1'b1;
      return;
    end
    if (edges_seen != EDGE_MAX) edges_seen++;
    ru = root_of(int'(u) - 1);
    rv = root_of(int'(v) - 1);
    if (ru != rv) begin
      if (group_size[ru] < group_size[rv]) begin
        swap = ru;
        ru = rv;
        rv = swap;
      end
      parent_of[rv] = IDX_W'(ru);
      group_size[ru] = group_size[ru] + group_size[rv];
    end
  endtask

  // Sum k(k-1)/2 over the groups of the live nodes, then clear
  task automatic close_graph(output clique_report_t rep);
    int n;
    longint unsigned total;
    longint unsigned k;
    n = live_nodes();
    for (int i = 0; i < MAX_NODES; i++) member_tally[i] = 0;
    for (int i = 0; i < n; i++) member_tally[root_of(i)]++;
    total = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      k = member_tally[i];
      if (k > 1) total += (k * (k - 1)) / 2;
    end
    rep.is_perfect = (total == edges_seen);
    rep.edge_total = edges_seen;
    rep.pair_sum = (total > PAIR_MAX) ? PAIR_MAX : total[PAIR_W-1:0];
    rep.bad_edge = bad_seen;
    clear_forest();
  endtask

  // Compare reports in order, then fold in config writes and accepted items
  always @(posedge clk) begin : watch
    clique_report_t got;
    clique_report_t next_rep;
    int errs;
    int pushed;
    int popped;
    errs = 0;
    pushed = 0;
    popped = 0;
    if (rst) begin
      node_limit = NODE_COUNT_RST;
      clear_forest();
      report_q.delete();
      fail_count <= 0;
      reports_pending <= 0;
    end else begin
      if (done) begin
        if (report_q.size() == 0) begin
          $error("report with none outstanding: is_perfect %0d edge_total %0d pair_sum %0d",
                 is_perfect, edge_total, pair_sum);
          errs++;
        end else begin
          got = report_q.pop_front();
          popped = 1;
          if (is_perfect !== got.is_perfect) begin
            $error("is_perfect: expected %0d, actual %0d", got.is_perfect, is_perfect);
            errs++;
          end
          if (edge_total !== got.edge_total) begin
            $error("edge_total: expected %0d, actual %0d", got.edge_total, edge_total);
            errs++;
          end
          if (pair_sum !== got.pair_sum) begin
            $error("pair_sum: expected %0d, actual %0d", got.pair_sum, pair_sum);
            errs++;
          end
          if (bad_edge !== got.bad_edge) begin
            $error("bad_edge: expected %0d, actual %0d", got.bad_edge, bad_edge);
            errs++;
          end
        end
      end
      if (cfg_we) node_limit = cfg_wdata;
      if (start && !busy) begin
        if (op == OP_FINISH) begin
          close_graph(next_rep);
          report_q.insert(report_q.size(), next_rep);
          pushed = 1;
        end else begin
          join_edge(node_u, node_v);
        end
      end
      fail_count <= fail_count + errs;
      reports_pending <= reports_pending + pushed - popped;
    end
  end

endmodule

// ----- tb/sv/component_clique_check_top_test.sv -----
// Testbench top for the component clique checker: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module component_clique_check_top_test;
  import ccc_pkg::*;

  localparam int MAX_NODES = 1024;
  localparam int RANDOM_ITEMS = 1350;
  localparam longint TIMEOUT_NS = 200_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              op = OP_ADD;
  logic [NODE_W-1:0] node_u = '0;
  logic [NODE_W-1:0] node_v = '0;
  logic              cfg_we = 1'b0;
  logic [NODE_W-1:0] cfg_wdata = '0;
  logic              busy;
  logic              done;
  logic              is_perfect;
  logic [EDGE_W-1:0] edge_total;
  logic [PAIR_W-1:0] pair_sum;
  logic              bad_edge;
  int                fail_count;
  int                reports_pending;

  int items_sent;
  int node_cap;
  bit steady;

  component_clique_check_top #(.MAX_NODES(MAX_NODES)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .node_u(node_u), .node_v(node_v), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .is_perfect(is_perfect), .edge_total(edge_total),
    .pair_sum(pair_sum), .bad_edge(bad_edge)
  );

  clique_report_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .node_u(node_u), .node_v(node_v), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .is_perfect(is_perfect), .edge_total(edge_total),
    .pair_sum(pair_sum), .bad_edge(bad_edge),
    .fail_count(fail_count), .reports_pending(reports_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in a steady stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_item(logic o, logic [NODE_W-1:0] u, logic [NODE_W-1:0] v);
    int gap;
    start <= 1'b1;
    op <= o;
    node_u <= u;
    node_v <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_edge(int u, int v);
    send_item(OP_ADD, NODE_W'(u), NODE_W'(v));
  endtask

  task automatic finish_graph();
    send_item(OP_FINISH, NODE_W'($urandom_range(0, 2047)), NODE_W'($urandom_range(0, 2047)));
  endtask

  // Stop sending until every report is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_node_count(int value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= NODE_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    node_cap = (value > MAX_NODES) ? MAX_NODES : value;
  endtask

  // Mostly a live node, now and then any 11-bit id
  function automatic int pick_node();
    if (node_cap == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
    return $urandom_range(1, node_cap);
  endfunction

  // Disjoint complete groups, with a rare stray edge to spoil them
  task automatic build_cliques(int budget);
    int base;
    int g;
    int used;
    used = 0;
    base = $urandom_range(1, node_cap);
    while (base <= node_cap && used < budget) begin
      g = $urandom_range(1, 6);
      if (base + g - 1 > node_cap) g = node_cap - base + 1;
      for (int a = base; a < base + g; a++) begin
        for (int b = a + 1; b < base + g; b++) begin
          if ($urandom_range(0, 1) == 0) add_edge(a, b);
          else add_edge(b, a);
          used++;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        add_edge(pick_node(), pick_node());
        used++;
      end
      base += g;
    end
  endtask

  task automatic random_edges(int budget);
    int u;
    for (int i = 0; i < budget; i++) begin
      u = pick_node();
      if ($urandom_range(0, 11) == 0) add_edge(u, u);
      else add_edge(u, pick_node());
    end
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("component_clique_check_top_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int r;
    int count;
    int budget;
    items_sent = 0;
    node_cap = MAX_NODES;
    steady = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Triangle at the reset count: a perfect graph
    add_edge(1, 2);
    add_edge(2, 3);
    add_edge(3, 1);
    finish_graph();
    // Duplicate edge: counted twice, pair sum once
    add_edge(1, 2);
    add_edge(2, 1);
    finish_graph();
    // Self-loop at the top node: counted, joins nothing
    add_edge(1024, 1024);
    finish_graph();
    // Bad endpoints: zero, one past the count, all ones
    add_edge(0, 5);
    add_edge(1025, 3);
    add_edge(2047, 2047);
    add_edge(4, 5);
    finish_graph();
    // Single node
    set_node_count(1);
    add_edge(1, 1);
    add_edge(1, 2);
    finish_graph();
    // No valid nodes at all
    set_node_count(0);
    add_edge(1, 1);
    finish_graph();
    // Count above the node limit is clamped
    set_node_count(2047);
    add_edge(1024, 1);
    add_edge(1025, 1);
    finish_graph();
    // Shrink the count with edges still held
    set_node_count(16);
    add_edge(1, 2);
    add_edge(15, 16);
    add_edge(16, 1);
    set_node_count(2);
    finish_graph();

    // Random phases, each with its own node count
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) count = $urandom_range(1, 40);
      else if (r < 78) count = 1024;
      else if (r < 84) count = $urandom_range(0, 2047);
      else if (r < 88) count = 0;
      else if (r < 92) count = 1;
      else if (r < 96) count = 2047;
      else count = $urandom_range(41, 200);
      set_node_count(count);
      steady = ($urandom_range(0, 3) == 0);
      budget = $urandom_range(4, 40);
      if (node_cap >= 2 && $urandom_range(0, 2) != 0) build_cliques(budget);
      else random_edges(budget);
      // Leave some graphs open so the next count change lands mid-stream
      if ($urandom_range(0, 7) != 0) finish_graph();
    end
    steady = 1'b0;
    finish_graph();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("component_clique_check_top_test: done, clean");
    end else begin
      $display("component_clique_check_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ccc_pkg.sv
rtl/ccc_ram.sv
rtl/component_clique_check_top.sv
tb/sv/clique_report_checker.sv
tb/sv/component_clique_check_top_test.sv
